>>> hw/rtl/first_free_slot_owner_table_core_defines.svh
// Assertion macros used by the checker of the slot owner table.
`ifndef FIRST_FREE_SLOT_OWNER_TABLE_CORE_DEFINES_SVH
`define FIRST_FREE_SLOT_OWNER_TABLE_CORE_DEFINES_SVH

// Same-cycle implication.
`define SOT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SOT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sot_pkg.sv
package sot_pkg;

    localparam int SLOT_W    = 7;
    localparam int GRP_W     = 8;
    localparam int GRP_IW    = 3;
    localparam int CAP_RESET = 64;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [1:0] {
        OP_RESERVE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_INVALID      = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } t_status;

endpackage

>>> hw/rtl/first_free_slot_owner_table_core.sv
// A request accepted in S_IDLE is executed in S_EXEC; its result is registered and strobed by o_done.
// No new request is taken while busy: each request passes the owner RAM read, then the S_EXEC
// read-modify-write step that also picks the lowest free slot from registered group results.
// Reset (synchronous, active low): capacity 64 (clamped to MAX_SLOTS), all slots free.
// A capacity write clears the table at once through the occupancy bits.
module first_free_slot_owner_table_core
    import sot_pkg::*;
#(
    parameter int MAX_SLOTS = 64,
    parameter int ID_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic [ID_BITS-1:0] i_owner_id,
    input  logic [SLOT_W-1:0]  i_slot_number,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SLOT_W-1:0]  i_cfg_data,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [SLOT_W-1:0]  o_granted_slot,
    output logic [ID_BITS-1:0] o_holder_id,
    output logic [SLOT_W-1:0]  o_free_count,
    output logic [SLOT_W-1:0]  o_used_count
);

    // Capacity is 7 bits wide, so no slot above the 7-bit range is ever used.
    localparam int USE_SLOTS = (MAX_SLOTS < (1 << SLOT_W)) ? MAX_SLOTS : (1 << SLOT_W);
    localparam int AW        = $clog2(USE_SLOTS);
    localparam int NGRP      = (USE_SLOTS + GRP_W - 1) / GRP_W;
    localparam int OCC_W     = NGRP * GRP_W;
    localparam int CAP_RST   = (CAP_RESET < USE_SLOTS) ? CAP_RESET : USE_SLOTS;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state              r_state;
    t_slot               r_cap;
    t_slot               r_free;
    t_slot               r_used;
    logic [OCC_W-1:0]    r_occ;
    logic [1:0]          r_op;
    logic [ID_BITS-1:0]  r_id;
    logic [AW-1:0]       r_addr;
    logic                r_slot_ok;
    logic                r_done;
    t_status             r_status;
    t_slot               r_granted;
    logic [ID_BITS-1:0]  r_holder;
    logic [NGRP-1:0]     r_grp_any;
    logic [GRP_IW-1:0]   r_grp_idx [NGRP];

    logic                w_accept;
    logic                w_cfg;
    t_slot               w_cfg_cap;
    t_slot               w_slot_m1;
    logic [AW-1:0]       w_raddr;
    logic [ID_BITS-1:0]  w_rdata;
    logic [OCC_W-1:0]    w_elig;
    logic [GRP_IW-1:0]   w_lidx [NGRP];
    logic                w_found;
    t_slot               w_gidx;
    logic                w_cur_occ;
    logic                w_we;

    t_status             n_status;
    t_slot               n_granted;
    logic [ID_BITS-1:0]  n_holder;
    t_slot               n_free;
    t_slot               n_used;
    logic [OCC_W-1:0]    n_occ;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_accept    = start && (r_state == S_IDLE);
    assign w_cfg       = i_cfg_valid && o_cfg_ready;

    assign w_slot_m1 = i_slot_number - t_slot'(1);
    assign w_raddr   = w_slot_m1[AW-1:0];

    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_cap = t_slot'(1);
        end else if ({1'b0, i_cfg_data} > (SLOT_W + 1)'(USE_SLOTS)) begin
            w_cfg_cap = t_slot'(USE_SLOTS);
        end else begin
            w_cfg_cap = i_cfg_data;
        end
    end

    // First level of the free-slot search: lowest free slot inside each group of eight.
    always_comb begin
        for (int i = 0; i < OCC_W; i++) begin
            w_elig[i] = !r_occ[i] && (i < int'(r_cap));
        end
        for (int g = 0; g < NGRP; g++) begin
            w_lidx[g] = '0;
            for (int j = GRP_W - 1; j >= 0; j--) begin
                if (w_elig[g*GRP_W + j]) begin
                    w_lidx[g] = GRP_IW'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_any <= '0;
        end else begin
            for (int g = 0; g < NGRP; g++) begin
                r_grp_any[g] <= |w_elig[g*GRP_W +: GRP_W];
                r_grp_idx[g] <= w_lidx[g];
            end
        end
    end

    // Second level: lowest group that still has a free slot.
    always_comb begin
        w_found = 1'b0;
        w_gidx  = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                w_found = 1'b1;
                w_gidx  = t_slot'(g * GRP_W) + t_slot'(r_grp_idx[g]);
            end
        end
    end

    assign w_cur_occ = r_occ[r_addr];

    always_comb begin
        n_status  = ST_INVALID;
        n_granted = '0;
        n_holder  = '0;
        n_free    = r_free;
        n_used    = r_used;
        n_occ     = r_occ;
        w_we      = 1'b0;
        unique case (r_op)
            OP_RESERVE: begin
                if (r_id != '0) begin
                    if (w_found) begin
                        n_status              = ST_OK;
                        n_granted             = w_gidx + t_slot'(1);
                        n_occ[w_gidx[AW-1:0]] = 1'b1;
                        n_free                = r_free - t_slot'(1);
                        n_used                = r_used + t_slot'(1);
                        w_we                  = (r_state == S_EXEC);
                    end else begin
                        n_status = ST_FULL;
                    end
                end
            end
            OP_RELEASE: begin
                if (r_slot_ok) begin
                    if (w_cur_occ) begin
                        n_status      = ST_OK;
                        n_holder      = w_rdata;
                        n_occ[r_addr] = 1'b0;
                        n_free        = r_free + t_slot'(1);
                        n_used        = r_used - t_slot'(1);
                    end else begin
                        n_status = ST_ALREADY_FREE;
                    end
                end
            end
            OP_QUERY: begin
                if (r_slot_ok) begin
                    n_status = ST_OK;
                    n_holder = w_cur_occ ? w_rdata : '0;
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    sot_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (USE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_gidx[AW-1:0]),
        .i_wdata (r_id),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cap   <= t_slot'(CAP_RST);
            r_free  <= t_slot'(CAP_RST);
            r_used  <= '0;
            r_occ   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op      <= i_op;
                        r_id      <= i_owner_id;
                        r_addr    <= w_raddr;
                        r_slot_ok <= (i_slot_number != '0) && (i_slot_number <= r_cap);
                        r_state   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_done    <= 1'b1;
                    r_status  <= n_status;
                    r_granted <= n_granted;
                    r_holder  <= n_holder;
                    r_free    <= n_free;
                    r_used    <= n_used;
                    r_occ     <= n_occ;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // New capacity drops every claim.
            if (w_cfg) begin
                r_cap  <= w_cfg_cap;
                r_free <= w_cfg_cap;
                r_used <= '0;
                r_occ  <= '0;
            end
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_granted_slot = r_granted;
    assign o_holder_id    = r_holder;
    assign o_free_count   = r_free;
    assign o_used_count   = r_used;

endmodule

>>> hw/rtl/sot_ram.sv
module sot_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/sot_checker.sv
`include "first_free_slot_owner_table_core_defines.svh"

module sot_checker
    import sot_pkg::*;
#(
    parameter int ID_BITS = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input logic [1:0]         o_status,
    input logic [SLOT_W-1:0]  o_granted_slot,
    input logic [ID_BITS-1:0] o_holder_id
);

    // An accepted request holds busy for one cycle, then its result shows while idle.
    `SOT_ASSERT_NEXT(a_accept_done, i_clk, i_rst_n, start && !busy, busy ##1 (o_done && !busy), "request result not strobed two cycles after accept")

    `SOT_ASSERT_NEXT(a_done_gap, i_clk, i_rst_n, o_done, !o_done, "result strobes in consecutive cycles")

    `SOT_ASSERT_SAME(a_grant_ok, i_clk, i_rst_n, o_done && (o_granted_slot != '0), (o_status == ST_OK) && (o_holder_id == '0), "granted slot with bad status or holder")

    `SOT_ASSERT_SAME(a_err_clean, i_clk, i_rst_n, o_done && (o_status != ST_OK), (o_granted_slot == '0) && (o_holder_id == '0), "failed request carries slot or holder")

endmodule

bind first_free_slot_owner_table_core sot_checker #(.ID_BITS(ID_BITS)) u_sot_checker (.*);
